// ===== design/fct_pkg.sv =====
// Shared types, codes and constants for the frame classifier and source-address tally.
package fct_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 24;
    localparam int WIRE_W  = 17;
    localparam int ENTRY_W = ADDR_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // word layouts
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;

    // length on the wire
    localparam logic [15:0]       LEN_SHORT_MAX = 16'd60;
    localparam logic [WIRE_W-1:0] WIRE_MIN      = 17'd64;
    localparam logic [WIRE_W-1:0] FCS_BYTES     = 17'd4;

    // type/length field and LLC header values
    localparam logic [15:0] ETH2_TYPE_FLOOR = 16'h05D0;
    localparam logic [15:0] LLC_SNAP        = 16'hAAAA;
    localparam logic [15:0] LLC_RAW         = 16'hFFFF;
    localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
    localparam logic [15:0] ETYPE_ARP       = 16'h0806;
    localparam logic [15:0] ETYPE_IPV6      = 16'h86DD;
    localparam logic [15:0] ETYPE_ATALK     = 16'h809B;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [1:0] {
        KIND_ETH2     = 2'd0,
        KIND_SNAP     = 2'd1,
        KIND_RAW      = 2'd2,
        KIND_LLC      = 2'd3
    } frame_kind_t;

    typedef enum logic [2:0] {
        NET_NONE  = 3'd0,
        NET_IPV4  = 3'd1,
        NET_ARP   = 3'd2,
        NET_IPV6  = 3'd3,
        NET_ATALK = 3'd4
    } net_proto_t;

    typedef enum logic [2:0] {
        TRANS_NONE = 3'd0,
        TRANS_TCP  = 3'd1,
        TRANS_UDP  = 3'd2,
        TRANS_ICMP = 3'd3,
        TRANS_IGMP = 3'd4
    } transport_t;

    typedef enum logic [1:0] {
        IP_NONE  = 2'd0,
        IP_KNOWN = 2'd1,
        IP_NEW   = 2'd2,
        IP_FULL  = 2'd3
    } ip_status_t;

    typedef struct packed {
        frame_kind_t       kind;
        net_proto_t        net;
        transport_t        trans;
        logic [WIRE_W-1:0] wire_len;
    } cls_t;

    typedef struct packed {
        logic       start;
        logic [ADDR_W-1:0] addr;
    } tbl_req_t;

    typedef struct packed {
        logic       done;
        ip_status_t status;
    } tbl_stat_t;

endpackage

// ===== design/fct_classify.sv =====
// Header decode: frame kind, network and transport protocol, wire length.
module fct_classify
(
    input  logic [15:0]  captured_len,
    input  logic [15:0]  ethertype,
    input  logic [15:0]  llc_word,
    input  logic [7:0]   ip_protocol,
    output fct_pkg::cls_t cls
);

    fct_pkg::frame_kind_t kind;
    fct_pkg::net_proto_t  net;
    fct_pkg::transport_t  trans;

    always_comb
    begin
        if (ethertype > fct_pkg::ETH2_TYPE_FLOOR)
        begin
            kind = fct_pkg::KIND_ETH2;
        end
        else
        begin
            unique case (llc_word)
                fct_pkg::LLC_SNAP: kind = fct_pkg::KIND_SNAP;
                fct_pkg::LLC_RAW:  kind = fct_pkg::KIND_RAW;
                default:           kind = fct_pkg::KIND_LLC;
            endcase
        end
    end

    always_comb
    begin
        net = fct_pkg::NET_NONE;
        if (kind == fct_pkg::KIND_ETH2)
        begin
            unique case (ethertype)
                fct_pkg::ETYPE_IPV4:  net = fct_pkg::NET_IPV4;
                fct_pkg::ETYPE_ARP:   net = fct_pkg::NET_ARP;
                fct_pkg::ETYPE_IPV6:  net = fct_pkg::NET_IPV6;
                fct_pkg::ETYPE_ATALK: net = fct_pkg::NET_ATALK;
                default:              net = fct_pkg::NET_NONE;
            endcase
        end
    end

    always_comb
    begin
        trans = fct_pkg::TRANS_NONE;
        if (net == fct_pkg::NET_IPV4)
        begin
            unique case (ip_protocol)
                fct_pkg::PROTO_TCP:  trans = fct_pkg::TRANS_TCP;
                fct_pkg::PROTO_UDP:  trans = fct_pkg::TRANS_UDP;
                fct_pkg::PROTO_ICMP: trans = fct_pkg::TRANS_ICMP;
                fct_pkg::PROTO_IGMP: trans = fct_pkg::TRANS_IGMP;
                default:             trans = fct_pkg::TRANS_NONE;
            endcase
        end
    end

    assign cls.kind     = kind;
    assign cls.net      = net;
    assign cls.trans    = trans;
    assign cls.wire_len = (captured_len <= fct_pkg::LEN_SHORT_MAX) ? fct_pkg::WIRE_MIN
                        : ({1'b0, captured_len} + fct_pkg::FCS_BYTES);

endmodule

// ===== design/fct_table.sv =====
// Source-address table: one RAM of {address, count}, linear search, update and top tracking.
module fct_table
#(
    parameter int DEPTH = fct_pkg::TABLE_DEPTH_DEF,
    localparam int IDXW = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fct_pkg::tbl_req_t            req,
    output fct_pkg::tbl_stat_t           stat,
    output logic [IDXW-1:0]              slot,
    output logic [fct_pkg::COUNT_W-1:0]  count,
    output logic [CNTW-1:0]              used,
    output logic [IDXW-1:0]              best_slot,
    output logic [fct_pkg::COUNT_W-1:0]  best_count
);

    typedef enum logic [1:0] {
        T_IDLE   = 2'b01,
        T_SEARCH = 2'b10
    } tbl_state_t;

    localparam int AW = fct_pkg::ADDR_W;
    localparam int CW = fct_pkg::COUNT_W;
    localparam int EW = fct_pkg::ENTRY_W;

    tbl_state_t state_reg, state_next;
    logic [AW-1:0]   key_reg, key_next;
    logic [CNTW-1:0] issue_reg, issue_next;
    logic            pvld_reg, pvld_next;
    logic [IDXW-1:0] pidx_reg, pidx_next;
    logic [CNTW-1:0] used_reg, used_next;
    logic [IDXW-1:0] best_slot_reg, best_slot_next;
    logic [CW-1:0]   best_cnt_reg, best_cnt_next;
    logic            done_reg, done_next;
    fct_pkg::ip_status_t status_reg, status_next;
    logic [IDXW-1:0] slot_reg, slot_next;
    logic [CW-1:0]   count_reg, count_next;

    // single-port-read, single-port-write RAM
    logic [EW-1:0]   mem_array [DEPTH];
    logic [EW-1:0]   rd_data_reg;
    logic            rd_en;
    logic [IDXW-1:0] rd_addr;
    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    logic [EW-1:0]   wr_data;

    logic            hit;
    logic            last;
    logic            full;
    logic [CW-1:0]   rd_count;
    logic [CW-1:0]   inc_count;
    logic            cand_en;
    logic [IDXW-1:0] cand_slot;
    logic [CW-1:0]   cand_cnt;
    logic            better;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_count  = rd_data_reg[CW-1:0];
    assign inc_count = (rd_count == fct_pkg::COUNT_MAX) ? rd_count : (rd_count + 1'b1);
    assign hit       = pvld_reg && (rd_data_reg[EW-1:CW] == key_reg);
    assign last      = pvld_reg && ((CNTW'(pidx_reg) + 1'b1) == used_reg);
    assign full      = (used_reg == CNTW'(DEPTH));
    // highest count wins, lowest slot on a tie
    assign better    = (cand_cnt > best_cnt_reg)
                    || ((cand_cnt == best_cnt_reg) && (cand_slot < best_slot_reg));

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        issue_next     = issue_reg;
        pvld_next      = 1'b0;
        pidx_next      = pidx_reg;
        used_next      = used_reg;
        best_slot_next = best_slot_reg;
        best_cnt_next  = best_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IDXW-1:0];
        wr_en          = 1'b0;
        wr_addr        = used_reg[IDXW-1:0];
        wr_data        = {key_reg, CW'(1)};
        cand_en        = 1'b0;
        cand_slot      = used_reg[IDXW-1:0];
        cand_cnt       = CW'(1);

        unique case (state_reg)
            T_IDLE:
            begin
                if (req.start)
                begin
                    key_next = req.addr;
                    if (used_reg == '0)
                    begin
                        // empty table: straight into slot 0
                        wr_en       = 1'b1;
                        wr_data     = {req.addr, CW'(1)};
                        cand_en     = 1'b1;
                        status_next = fct_pkg::IP_NEW;
                        slot_next   = used_reg[IDXW-1:0];
                        count_next  = CW'(1);
                        used_next   = used_reg + 1'b1;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        issue_next = '0;
                        state_next = T_SEARCH;
                    end
                end
            end

            T_SEARCH:
            begin
                // read slot issue_reg, compare the slot read last cycle
                if (issue_reg < used_reg)
                begin
                    rd_en      = 1'b1;
                    issue_next = issue_reg + 1'b1;
                    pvld_next  = 1'b1;
                    pidx_next  = issue_reg[IDXW-1:0];
                end
                if (hit)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = pidx_reg;
                    wr_data     = {key_reg, inc_count};
                    cand_en     = 1'b1;
                    cand_slot   = pidx_reg;
                    cand_cnt    = inc_count;
                    status_next = fct_pkg::IP_KNOWN;
                    slot_next   = pidx_reg;
                    count_next  = inc_count;
                    pvld_next   = 1'b0;
                    done_next   = 1'b1;
                    state_next  = T_IDLE;
                end
                else if (last)
                begin
                    if (full)
                    begin
                        status_next = fct_pkg::IP_FULL;
                        slot_next   = '0;
                        count_next  = '0;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        cand_en     = 1'b1;
                        status_next = fct_pkg::IP_NEW;
                        slot_next   = used_reg[IDXW-1:0];
                        count_next  = CW'(1);
                        used_next   = used_reg + 1'b1;
                    end
                    pvld_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase

        if (cand_en && better)
        begin
            best_slot_next = cand_slot;
            best_cnt_next  = cand_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pvld_reg      <= 1'b0;
            used_reg      <= '0;
            best_slot_reg <= '0;
            best_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            status_reg    <= fct_pkg::IP_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            pvld_reg      <= pvld_next;
            used_reg      <= used_next;
            best_slot_reg <= best_slot_next;
            best_cnt_reg  <= best_cnt_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        issue_reg <= issue_next;
        pidx_reg  <= pidx_next;
        slot_reg  <= slot_next;
        count_reg <= count_next;
    end

    assign stat.done   = done_reg;
    assign stat.status = status_reg;
    assign slot        = slot_reg;
    assign count       = count_reg;
    assign used        = used_reg;
    assign best_slot   = best_slot_reg;
    assign best_count  = best_cnt_reg;

endmodule

// ===== design/frame_classify_ip_tally.sv =====
// Top level: frame classifier with IPv4 source-address tally and top-sender tracking.
//
// Usage
//   Slave side (s_*) takes one frame summary per word; master side (m_*) gives
//   one result word per summary, in order. A word moves when tvalid and tready
//   are both high at a rising clock edge.
//   Non-IPv4 frames are only classified. IPv4 frames also search the address
//   table, which sits in one RAM of {address, count} with a registered read
//   port; the search reads one slot per cycle over the filled slots only.
// Search
//   A non-IPv4 frame skips the table; an IPv4 frame waits for the linear
//   table search through the RAM read port, which ends at a hit or after
//   the last filled slot. An empty table needs no search.
// Reset
//   rst_n clears the table fill count and the top sender; RAM contents are not
//   cleared, as only filled slots are ever read. No clearing pass is needed.
// Stall
//   The result sits in an output register; s_tready is high only while the
//   sequencer is idle: it stays low while a search runs and until a finished result has been placed in that register.
module frame_classify_ip_tally
#(
    parameter int TABLE_DEPTH = fct_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // captured_len[15:0], ethertype[31:16], llc_word[47:32],
    // ip_protocol[55:48], source_address[87:56]
    input  logic [fct_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_kind[1:0], net_proto[4:2], transport[7:5], wire_len[24:8],
    // ip_status[26:25], ip_slot[32:27], ip_count[56:33], unique_count[63:57],
    // top_slot[69:64], top_count[93:70], top_valid[94], zero pad[95]
    output logic [fct_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int CW   = fct_pkg::COUNT_W;

    // one-hot sequencer for one summary at a time
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_EMIT = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;
    fct_pkg::cls_t cls_now;
    fct_pkg::cls_t cls_reg, cls_next;
    logic          out_vld_reg, out_vld_next;
    logic [fct_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    fct_pkg::tbl_req_t  tbl_req;
    fct_pkg::tbl_stat_t tbl_stat;
    logic [IDXW-1:0]    tbl_slot;
    logic [CW-1:0]      tbl_count;
    logic [CNTW-1:0]    tbl_used;
    logic [IDXW-1:0]    tbl_best_slot;
    logic [CW-1:0]      tbl_best_cnt;

    logic s_fire;
    logic is_ipv4_now;
    logic is_ipv4_reg;
    logic load_out;
    logic top_valid;

    // result fields, trimmed to the port widths
    logic [IDXW+5:0] slot_ext;
    logic [IDXW+5:0] best_ext;
    logic [CNTW+6:0] used_ext;
    fct_pkg::ip_status_t res_status;
    logic [5:0]      res_slot;
    logic [CW-1:0]   res_count;

    fct_classify u_classify
    (
        .captured_len (s_tdata[15:0]),
        .ethertype    (s_tdata[31:16]),
        .llc_word     (s_tdata[47:32]),
        .ip_protocol  (s_tdata[55:48]),
        .cls          (cls_now)
    );

    fct_table
    #(
        .DEPTH (TABLE_DEPTH)
    )
    u_table
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (tbl_req),
        .stat       (tbl_stat),
        .slot       (tbl_slot),
        .count      (tbl_count),
        .used       (tbl_used),
        .best_slot  (tbl_best_slot),
        .best_count (tbl_best_cnt)
    );

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign is_ipv4_now = (cls_now.net == fct_pkg::NET_IPV4);
    assign is_ipv4_reg = (cls_reg.net == fct_pkg::NET_IPV4);

    // table is idle whenever the sequencer is idle
    assign tbl_req.start = s_fire && is_ipv4_now;
    assign tbl_req.addr  = s_tdata[87:56];

    // output register free, or being emptied this cycle
    assign load_out = (state_reg == ST_EMIT) && (!out_vld_reg || m_tready);

    assign slot_ext   = {6'b0, tbl_slot};
    assign best_ext   = {6'b0, tbl_best_slot};
    assign used_ext   = {7'b0, tbl_used};
    assign top_valid  = (tbl_used != '0);
    assign res_status = is_ipv4_reg ? tbl_stat.status : fct_pkg::IP_NONE;
    assign res_slot   = is_ipv4_reg ? slot_ext[5:0] : 6'd0;
    assign res_count  = is_ipv4_reg ? tbl_count : '0;

    always_comb
    begin
        state_next    = state_reg;
        cls_next      = cls_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    cls_next   = cls_now;
                    state_next = is_ipv4_now ? ST_LOOK : ST_EMIT;
                end
            end

            ST_LOOK:
            begin
                if (tbl_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_vld_next  = 1'b1;
            out_data_next = {1'b0,
                             top_valid,
                             tbl_best_cnt,
                             best_ext[5:0],
                             used_ext[6:0],
                             res_count,
                             res_slot,
                             res_status,
                             cls_reg.wire_len,
                             cls_reg.trans,
                             cls_reg.net,
                             cls_reg.kind};
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg      <= cls_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/fct_checker.sv =====
// Port-level checks for the frame classifier and tally, bound to the top level.
module fct_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic [fct_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [fct_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);

    logic [1:0]  st;
    logic [5:0]  ip_slot;
    logic [23:0] ip_count;
    logic [23:0] top_count;
    logic        top_valid;
    logic        in_seen;

    assign st        = m_tdata[26:25];
    assign ip_slot   = m_tdata[32:27];
    assign ip_count  = m_tdata[56:33];
    assign top_count = m_tdata[93:70];
    assign top_valid = m_tdata[94];
    assign in_seen   = s_tvalid && s_tready && (s_tdata != '0 || s_tdata == '0);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // uncounted or dropped frames carry no slot and no count
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == fct_pkg::IP_NONE || st == fct_pkg::IP_FULL)
        |-> ip_slot == 6'd0 && ip_count == 24'd0)
        else $error("slot or count set for an uncounted frame");

    // a counted or dropped address comes only from an IPv4 Ethernet II frame
    a_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st != fct_pkg::IP_NONE
        |-> m_tdata[1:0] == fct_pkg::KIND_ETH2 && m_tdata[4:2] == fct_pkg::NET_IPV4
            && top_valid)
        else $error("table status on a non-IPv4 frame or empty table");

    // the top sender never counts fewer packets than the address just counted
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == fct_pkg::IP_KNOWN || st == fct_pkg::IP_NEW)
        |-> top_count >= ip_count && ip_count != 24'd0)
        else $error("top count below counted address");

    // no input word is taken while a result is still being worked on
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_seen |=> !s_tready)
        else $error("input taken back to back");

endmodule

bind frame_classify_ip_tally fct_checker u_fct_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== tb/fct_tally_checker.sv =====
// Checker for the frame classifier: predicts every result word and compares it field by field.
module fct_tally_checker
    import fct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    output int                     mismatches,
    output int                     awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = TABLE_DEPTH_DEF;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        proto;
        logic [15:0]       llc;
        logic [15:0]       et;
        logic [15:0]       len;
    } frame_summary_t;

    typedef struct packed {
        logic               pad;
        logic               top_valid;
        logic [COUNT_W-1:0] top_count;
        logic [5:0]         top_slot;
        logic [6:0]         uniq;
        logic [COUNT_W-1:0] ip_count;
        logic [5:0]         ip_slot;
        ip_status_t         status;
        logic [WIRE_W-1:0]  wire_len;
        transport_t         trans;
        net_proto_t         net;
        frame_kind_t        kind;
    } frame_result_t;

    // own copy of the source-address table
    logic [ADDR_W-1:0]  held_addr  [SLOTS];
    logic [COUNT_W-1:0] held_count [SLOTS];
    int unsigned        used_slots = 0;
    int unsigned        lead_slot  = 0;
    logic [COUNT_W-1:0] lead_count = '0;

    frame_result_t due_results[$];
    int            words_seen = 0;

    task automatic report(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns  ERROR  %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input int n, input string name,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report($sformatf("word %0d %s: got 0x%0h, expected 0x%0h", n, name, got, want));
    endtask

    // Counts saturate at COUNT_MAX; reaching it would take far more words than a run holds.
    function automatic frame_result_t classify_and_tally(input frame_summary_t f);
        frame_result_t r;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        if (f.et > ETH2_TYPE_FLOOR)  r.kind = KIND_ETH2;
        else if (f.llc == LLC_SNAP)  r.kind = KIND_SNAP;
        else if (f.llc == LLC_RAW)   r.kind = KIND_RAW;
        else                         r.kind = KIND_LLC;
        r.wire_len = (f.len <= LEN_SHORT_MAX) ? WIRE_MIN : WIRE_W'(f.len) + FCS_BYTES;
        if (r.kind == KIND_ETH2)
        begin
            case (f.et)
                ETYPE_IPV4:  r.net = NET_IPV4;
                ETYPE_ARP:   r.net = NET_ARP;
                ETYPE_IPV6:  r.net = NET_IPV6;
                ETYPE_ATALK: r.net = NET_ATALK;
                default:     r.net = NET_NONE;
            endcase
        end
        if (r.net == NET_IPV4)
        begin
            case (f.proto)
                PROTO_TCP:  r.trans = TRANS_TCP;
                PROTO_UDP:  r.trans = TRANS_UDP;
                PROTO_ICMP: r.trans = TRANS_ICMP;
                PROTO_IGMP: r.trans = TRANS_IGMP;
                default:    r.trans = TRANS_NONE;
            endcase
            for (int i = 0; i < used_slots && !hit; i++)
            begin
                if (held_addr[i] == f.addr)
                begin
                    if (held_count[i] != COUNT_MAX)
                        held_count[i]++;
                    r.status   = IP_KNOWN;
                    r.ip_slot  = 6'(i);
                    r.ip_count = held_count[i];
                    hit        = 1'b1;
                end
            end
            if (!hit)
            begin
                if (used_slots < SLOTS)
                begin
                    held_addr[used_slots]  = f.addr;
                    held_count[used_slots] = 1;
                    r.status   = IP_NEW;
                    r.ip_slot  = 6'(used_slots);
                    r.ip_count = 1;
                    used_slots++;
                end
                else
                    r.status = IP_FULL;
            end
            // top sender: strict greater keeps the lowest slot on ties
            lead_slot  = 0;
            lead_count = '0;
            for (int i = 0; i < used_slots; i++)
            begin
                if (held_count[i] > lead_count)
                begin
                    lead_count = held_count[i];
                    lead_slot  = i;
                end
            end
        end
        r.uniq = 7'(used_slots);
        if (used_slots != 0)
        begin
            r.top_slot  = 6'(lead_slot);
            r.top_count = lead_count;
            r.top_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic compare_result(input int n, input frame_result_t got,
                                  input frame_result_t want);
        check_field(n, "frame_kind",   32'(got.kind),      32'(want.kind));
        check_field(n, "net_proto",    32'(got.net),       32'(want.net));
        check_field(n, "transport",    32'(got.trans),     32'(want.trans));
        check_field(n, "wire_len",     32'(got.wire_len),  32'(want.wire_len));
        check_field(n, "ip_status",    32'(got.status),    32'(want.status));
        check_field(n, "ip_slot",      32'(got.ip_slot),   32'(want.ip_slot));
        check_field(n, "ip_count",     32'(got.ip_count),  32'(want.ip_count));
        check_field(n, "unique_count", 32'(got.uniq),      32'(want.uniq));
        check_field(n, "top_slot",     32'(got.top_slot),  32'(want.top_slot));
        check_field(n, "top_count",    32'(got.top_count), 32'(want.top_count));
        check_field(n, "top_valid",    32'(got.top_valid), 32'(want.top_valid));
        check_field(n, "pad",          32'(got.pad),       32'(want.pad));
    endtask

    // Results are taken before summaries, so a word cannot match a summary of the same edge.
    always @(posedge clk)
    begin
        frame_result_t got;
        frame_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = frame_result_t'(m_tdata);
                if (due_results.size() == 0)
                    report($sformatf("word %0d arrived with no summary outstanding", words_seen));
                else
                begin
                    want = due_results.pop_front();
                    compare_result(words_seen, got, want);
                end
                words_seen++;
            end
            if (s_tvalid && s_tready)
                due_results.push_back(classify_and_tally(frame_summary_t'(s_tdata)));
            awaited <= due_results.size();
        end
    end

endmodule

// ===== tb/tb_frame_classify_ip_tally.sv =====
// Testbench top for the frame classifier and source-address tally: stimulus and verdict.
module tb_frame_classify_ip_tally;
    timeunit 1ns;
    timeprecision 1ps;
    import fct_pkg::*;

    localparam int RANDOM_FRAMES = 900;
    localparam int ADDR_POOL     = 80;      // more than the table holds, so it overflows
    localparam int SINK_HOLD     = 300;     // long receiver hold-off, in cycles
    localparam int HOLD_AT       = 200;     // random word at which that hold-off is requested
    localparam int DRAIN_AT      = 450;     // random word before which the sender waits for all
    localparam int TAIL_CYCLES   = 80;      // longer than the slowest search
    localparam int CYCLE_LIMIT   = 1000000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tvalid = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;

    int          mismatches;
    int          awaited;
    int          cycles      = 0;
    int          steady_left = 0;       // words still to send back to back
    logic        hold_req    = 1'b0;    // asks the receiver for its long hold-off
    logic [31:0] addr_pool [ADDR_POOL];

    frame_classify_ip_tally DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    fct_tally_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 80);
    endfunction

    // Distinct random source addresses; more than the table holds, so the later ones end up dropped.
    function automatic void fill_pool();
        bit clash;
        for (int k = 0; k < ADDR_POOL; k++)
        begin
            do
            begin
                addr_pool[k] = $urandom;
                clash = 1'b0;
                for (int j = 0; j < k; j++)
                    if (addr_pool[j] == addr_pool[k])
                        clash = 1'b1;
            end
            while (clash);
        end
    endfunction

    // Offers one summary word and waits for its acceptance, then may idle for a while.
    // Returns at a step where s_tvalid has not yet been assigned.
    task automatic offer(input logic [15:0] len, input logic [15:0] et, input logic [15:0] llc,
                         input logic [7:0] proto, input logic [31:0] addr);
        int gap;
        s_tdata  <= {addr, proto, llc, et, len};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(0, 99) < 3)
                steady_left = $urandom_range(15, 50);
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender pause: nothing offered until every result word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    // Receiver: alternating ready and stalled stretches, plus one long hold-off on request
    // so the output register fills and the block has to stall its input.
    initial
    begin
        int  nap;
        bit  hold_served;
        hold_served = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                nap = SINK_HOLD;
            end
            else
                nap = idle_len();
            if (nap != 0)
            begin
                m_tready <= 1'b0;
                repeat (nap) @(posedge clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(30, 120)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int          r;
        int          fresh;
        logic [15:0] len;
        logic [15:0] et;
        logic [15:0] llc;
        logic [7:0]  proto;
        logic [31:0] addr;

        fill_pool();
        fresh = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First word hits an empty table: top sender must read as absent.
        offer(16'd0,     ETYPE_ARP,        16'h0000, PROTO_TCP,  32'h0000_0000);
        // first IPv4 address takes slot 0; length right at the short-frame limit
        offer(LEN_SHORT_MAX, ETYPE_IPV4,   16'h0000, PROTO_TCP,  32'h0000_0000);
        // just above the limit; new address, tie at count 1 keeps slot 0 on top
        offer(16'd61,    ETYPE_IPV4,       16'hFFFF, PROTO_UDP,  32'hFFFF_FFFF);
        // longest frame; known address moves the top to slot 1
        offer(16'hFFFF,  ETYPE_IPV4,       16'hAAAA, PROTO_ICMP, 32'hFFFF_FFFF);
        // slot 0 draws level: the lower slot wins the tie
        offer(16'd64,    ETYPE_IPV4,       16'h1234, PROTO_IGMP, 32'h0000_0000);
        // unknown protocol numbers at both ends of the byte
        offer(16'd100,   ETYPE_IPV4,       16'h0000, 8'h00,      32'h0A00_0001);
        offer(16'd59,    ETYPE_IPV4,       16'h0000, 8'hFF,      32'h0A00_0001);
        offer(16'd59,    ETYPE_IPV6,       16'h0000, PROTO_TCP,  32'h0A00_0001);
        offer(16'd1500,  ETYPE_ATALK,      16'hFFFF, PROTO_UDP,  32'hFFFF_FFFF);
        // smallest type field that still counts as Ethernet II, and the largest
        offer(16'd70,    ETH2_TYPE_FLOOR + 16'd1, 16'hAAAA, PROTO_TCP, 32'h0000_0000);
        offer(16'd1,     16'hFFFF,         16'hFFFF, PROTO_TCP,  32'h0000_0000);
        // 802.3 kinds, where the floor value itself is a length and IP fields must be ignored; then IPv4 with LLC_RAW
        offer(16'd60,    ETH2_TYPE_FLOOR,  LLC_SNAP, PROTO_TCP,  32'h0000_0000);
        offer(16'd46,    16'h0000,         LLC_RAW,  PROTO_UDP,  32'hFFFF_FFFF);
        offer(16'd300,   16'h0100,         16'h0800, PROTO_TCP,  32'h0A00_0001);
        offer(16'd61,    ETH2_TYPE_FLOOR,  16'hAAAB, PROTO_ICMP, 32'h0000_0000);
        offer(16'd62,    ETYPE_IPV4,       LLC_RAW,  PROTO_UDP,  32'hC0A8_0101);
        drain_results();

        // Random part: mostly IPv4 words over a growing pool of addresses, so the table
        // fills and later overflows; the rest other protocols and 802.3 noise.
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n == HOLD_AT)
                hold_req <= 1'b1;
            if (n == DRAIN_AT)
                drain_results();
            len   = ($urandom_range(0, 99) < 20) ? 16'($urandom_range(0, 64)) : 16'($urandom);
            llc   = 16'($urandom);
            proto = 8'($urandom);
            addr  = $urandom;
            r     = $urandom_range(0, 99);
            if (r < 65)
            begin
                et = ETYPE_IPV4;
                case ($urandom_range(0, 9))
                    0: proto = PROTO_TCP;
                    1: proto = PROTO_UDP;
                    2: proto = PROTO_ICMP;
                    3: proto = PROTO_IGMP;
                    4: proto = PROTO_TCP;
                    5: proto = PROTO_UDP;
                    6: proto = PROTO_TCP;
                    default: ;
                endcase
                r = $urandom_range(0, 99);
                if (r < 20 && fresh < ADDR_POOL)
                begin
                    addr = addr_pool[fresh];
                    fresh++;
                end
                else if (r < 45)
                    addr = addr_pool[$urandom_range(0, 3)];    // a few heavy senders
                else if (r < 97)
                    addr = addr_pool[$urandom_range(0, (fresh < ADDR_POOL) ? fresh
                                                                           : ADDR_POOL - 1)];
            end
            else if (r < 75)
            begin
                case ($urandom_range(0, 2))
                    0:       et = ETYPE_ARP;
                    1:       et = ETYPE_IPV6;
                    default: et = ETYPE_ATALK;
                endcase
            end
            else if (r < 85)
                et = 16'($urandom_range(ETH2_TYPE_FLOOR + 1, 16'hFFFF));
            else
            begin
                et = 16'($urandom_range(0, ETH2_TYPE_FLOOR));
                case ($urandom_range(0, 2))
                    0:       llc = LLC_SNAP;
                    1:       llc = LLC_RAW;
                    default: ;
                endcase
            end
            offer(len, et, llc, proto, addr);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
